>>> rtl/core/set_assoc_lru_cache_sim_top_macros.svh
// Assertion macros shared by the cache RTL.
// Included by name from the modules that carry checks; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SALC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache check failed");
// Next-cycle implication.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache check failed");
`else
`define SALC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/salc_pkg.sv
// Shared types, codes and helpers for the set-associative LRU cache model.
// No dependencies; used by set_assoc_lru_cache_sim_top.
`default_nettype none

package salc_pkg;

    localparam int ADDR_FIELD_W = 48;
    localparam int COUNT_W      = 32;
    localparam int STAMP_W      = 32;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS  = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [ADDR_FIELD_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               second_hit;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
    } result_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_sim_top.sv
// Set-associative LRU cache model: config registers, set memory, lookup and victim scan.
// Depends on salc_pkg and set_assoc_lru_cache_sim_top_macros.svh.
`default_nettype none

`include "set_assoc_lru_cache_sim_top_macros.svh"

// Each access reads one whole set row (tag and use stamp of every way) from a
// single-port memory, compares all ways at once, and writes the row back. A hit
// or an unused kind passes through accept, lookup and write-back; a miss also
// runs the victim scan between lookup and write-back, one way per cycle,
// stopping at the first invalid way or at the last way in use.
// A modify is handled as one memory pass: its store always hits.
// Valid bits sit in flip-flops cleared by reset, so no clearing pass is needed.
// The next transfer is taken while a finished result waits in the output
// register; the write-back holds until that result is taken.
module set_assoc_lru_cache_sim_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4,
    parameter int ADDR_WIDTH   = 48
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire salc_pkg::request_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output salc_pkg::result_t                       out_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SW       = salc_pkg::STAMP_W;
    localparam int CW       = salc_pkg::COUNT_W;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] tag;
        logic [SW-1:0]         stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] set_row_t;

    // ---------------- configuration ----------------
    logic [2:0] set_bits_reg;
    logic [2:0] ways_reg;
    logic [5:0] block_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd0;
            ways_reg       <= 3'd1;
            block_bits_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                salc_pkg::REG_SET_BITS:    set_bits_reg   <= cfg_data[2:0];
                salc_pkg::REG_WAYS_IN_USE: ways_reg       <= cfg_data[2:0];
                salc_pkg::REG_BLOCK_BITS:  block_bits_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // ---------------- address split ----------------
    logic [3:0]            sb_eff;
    logic [4:0]            ways_raw;
    logic [4:0]            ways_eff;
    logic [WAY_W-1:0]      in_last_way;
    logic [ADDR_WIDTH-1:0] in_addr;
    logic [ADDR_WIDTH-1:0] in_blk;
    logic [ADDR_WIDTH-1:0] in_tag;
    logic [SET_IW-1:0]     in_set;

    always_comb
    begin
        sb_eff = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits_reg);
        ways_raw = (ways_reg == 3'd0) ? 5'd1 : 5'(ways_reg);
        ways_eff = (ways_raw > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : ways_raw;
        in_last_way = WAY_W'(ways_eff - 5'd1);
        in_addr = ADDR_WIDTH'({{(64 - salc_pkg::ADDR_FIELD_W){1'b0}}, in_data.address});
        in_blk = in_addr >> block_bits_reg;
        in_tag = in_blk >> sb_eff;
        in_set = in_blk[SET_IW-1:0] & ~({SET_IW{1'b1}} << sb_eff);
    end

    // ---------------- control ----------------
    salc_pkg::state_t   state_reg, state_next;
    logic               accept;
    logic               wr_go;
    logic               out_valid_reg;
    salc_pkg::result_t  out_data_reg;

    salc_pkg::kind_t    kind_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [SET_IW-1:0]  set_reg;
    logic [WAY_W-1:0]   last_way_reg;
    logic [WAY_W-1:0]   scan_way_reg;
    logic [WAY_W-1:0]   sel_way_reg;
    logic [SW-1:0]      best_age_reg;
    salc_pkg::outcome_t outcome_reg;
    set_row_t           rd_row_reg;
    logic [MAX_WAYS-1:0] valid_row_reg;
    logic [MAX_WAYS-1:0] valid_reg [NUM_SETS];
    logic [SW-1:0]      clock_reg, clock_next;
    logic [CW-1:0]      hit_reg, hit_next;
    logic [CW-1:0]      miss_reg, miss_next;
    logic [CW-1:0]      evict_reg, evict_next;

    set_row_t set_mem [NUM_SETS];

    // Parallel tag compare across the ways in use; lowest matching way wins.
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if ((WAY_W'(w) <= last_way_reg) && valid_row_reg[w] && (rd_row_reg[w].tag == tag_reg))
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Victim scan: one way per cycle.
    logic [SW-1:0] clk1;
    logic [SW-1:0] scan_age;
    logic          scan_valid;
    logic          scan_better;
    logic          scan_last;

    always_comb
    begin
        clk1        = clock_reg + SW'(1);
        scan_valid  = valid_row_reg[scan_way_reg];
        scan_age    = clk1 - rd_row_reg[scan_way_reg].stamp;
        scan_better = (scan_way_reg == '0) || (scan_age > best_age_reg);
        scan_last   = (scan_way_reg == last_way_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            salc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = salc_pkg::ST_LOOKUP;
            end
            salc_pkg::ST_LOOKUP:
            begin
                if (kind_reg == salc_pkg::KIND_NONE || hit_any)
                    state_next = salc_pkg::ST_WRITE;
                else
                    state_next = salc_pkg::ST_SCAN;
            end
            salc_pkg::ST_SCAN:
            begin
                if (!scan_valid || scan_last)
                    state_next = salc_pkg::ST_WRITE;
            end
            salc_pkg::ST_WRITE:
            begin
                if (wr_go)
                    state_next = salc_pkg::ST_IDLE;
            end
            default: state_next = salc_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready = (state_reg == salc_pkg::ST_IDLE);
        wr_go    = (state_reg == salc_pkg::ST_WRITE) && (!out_valid_reg || out_ready);
    end

    assign accept = in_valid && in_ready;

    // ---------------- write-back values ----------------
    logic          does_access;
    logic          is_modify;
    logic [SW-1:0] stamp_new;
    set_row_t      new_row;

    always_comb
    begin
        does_access = (kind_reg != salc_pkg::KIND_NONE);
        is_modify   = (kind_reg == salc_pkg::KIND_MODIFY);
        stamp_new   = is_modify ? clock_reg + SW'(2) : clk1;
        new_row     = rd_row_reg;
        new_row[sel_way_reg].tag   = tag_reg;
        new_row[sel_way_reg].stamp = stamp_new;

        clock_next = clock_reg;
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        evict_next = evict_reg;
        if (does_access)
        begin
            clock_next = stamp_new;
            if (outcome_reg == salc_pkg::OUT_HIT)
                hit_next = salc_pkg::sat_inc(hit_reg);
            else
                miss_next = salc_pkg::sat_inc(miss_reg);
            if (outcome_reg == salc_pkg::OUT_EVICT)
                evict_next = salc_pkg::sat_inc(evict_reg);
            // the store half of a modify always hits
            if (is_modify)
                hit_next = salc_pkg::sat_inc(hit_next);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= salc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            clock_reg     <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_go)
            begin
                out_valid_reg <= 1'b1;
                clock_reg     <= clock_next;
                hit_reg       <= hit_next;
                miss_reg      <= miss_next;
                evict_reg     <= evict_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
                valid_reg[s] <= '0;
        end
        else if (wr_go && does_access)
        begin
            valid_reg[set_reg][sel_way_reg] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= salc_pkg::kind_t'(in_data.kind);
            tag_reg       <= in_tag;
            set_reg       <= in_set;
            last_way_reg  <= in_last_way;
            valid_row_reg <= valid_reg[in_set];
        end
        if (state_reg == salc_pkg::ST_LOOKUP)
        begin
            sel_way_reg  <= hit_way;
            outcome_reg  <= salc_pkg::OUT_HIT;
            scan_way_reg <= '0;
            best_age_reg <= '0;
        end
        if (state_reg == salc_pkg::ST_SCAN)
        begin
            if (!scan_valid)
            begin
                sel_way_reg <= scan_way_reg;
                outcome_reg <= salc_pkg::OUT_FILL;
            end
            else
            begin
                if (scan_better)
                begin
                    sel_way_reg  <= scan_way_reg;
                    best_age_reg <= scan_age;
                end
                outcome_reg <= salc_pkg::OUT_EVICT;
            end
            scan_way_reg <= scan_way_reg + WAY_W'(1);
        end
        if (wr_go)
        begin
            out_data_reg.outcome        <= does_access ? outcome_reg : salc_pkg::OUT_HIT;
            out_data_reg.second_hit     <= is_modify;
            out_data_reg.hit_total      <= hit_next;
            out_data_reg.miss_total     <= miss_next;
            out_data_reg.eviction_total <= evict_next;
        end
    end

    // Set memory: one row read per transfer, one row written per write-back of a load, store or modify
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_row_reg <= set_mem[in_set];
        if (wr_go && does_access)
            set_mem[set_reg] <= new_row;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    `SALC_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept, state_reg == salc_pkg::ST_LOOKUP)
    `SALC_ASSERT_NOW(a_result_after_write, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == salc_pkg::ST_WRITE)
    `SALC_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_reg == salc_pkg::ST_SCAN, scan_way_reg <= last_way_reg)
    `SALC_ASSERT_NOW(a_evict_le_miss, clk, rst_n, 1'b1, evict_reg <= miss_reg)
    `SALC_ASSERT_NEXT(a_hits_monotonic, clk, rst_n, 1'b1, hit_reg >= $past(hit_reg))

endmodule

`default_nettype wire
